>>> hdl/c8ie_pkg.sv
`default_nettype none
// ============================================================================
// c8ie_pkg : shared types and constants for the CHIP-8 execute core
// Payload structs, opcode and error codes, register map, sizing constants.
// ============================================================================
package c8ie_pkg;

    // sizing
    localparam int ADDR_BITS     = 12;                          // counter / stack entry width
    localparam int FETCH_BITS    = 12;                          // reported fetch address width
    localparam int STK_DEPTH     = 16;                          // return stack entries
    localparam int STK_IDX_BITS  = (STK_DEPTH > 1) ? $clog2(STK_DEPTH) : 1;
    localparam int STK_LVL_BITS  = $clog2(STK_DEPTH + 1);
    localparam int NUM_VREGS     = 16;
    localparam int VREG_BITS     = $clog2(NUM_VREGS);
    localparam int PADDR_BITS    = 3;
    localparam int PDATA_BITS    = 32;

    typedef logic [ADDR_BITS-1:0]    addr_t;
    typedef logic [STK_LVL_BITS-1:0] lvl_t;
    typedef logic [STK_IDX_BITS-1:0] stk_idx_t;
    typedef logic [VREG_BITS-1:0]    vidx_t;

    localparam logic [FETCH_BITS-1:0] PROG_START_RESET = 12'd512;

    // register map (register index = paddr[2])
    localparam logic REG_PROGRAM_START = 1'b0;

    // flag register and V0 indices
    localparam vidx_t REG_VF = 4'hF;
    localparam vidx_t REG_V0 = 4'h0;

    // top nibble opcodes
    localparam logic [3:0] OP_SYS  = 4'h0;
    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_CALL = 4'h2;
    localparam logic [3:0] OP_SE   = 4'h3;
    localparam logic [3:0] OP_SNE  = 4'h4;
    localparam logic [3:0] OP_SEV  = 4'h5;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNEV = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV  = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_KEY  = 4'hE;

    // 8xyN sub-ops
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [11:0] NNN_CLS  = 12'h0E0;
    localparam logic [11:0] NNN_RET  = 12'h0EE;
    localparam logic [7:0]  KK_SKP   = 8'h9E;
    localparam logic [7:0]  KK_SKNP  = 8'hA1;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_OVERFLOW  = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_UNKNOWN   = 2'd3
    } err_t;

    typedef struct packed {
        logic [15:0] instruction;
        logic [7:0]  random_byte;
    } in_t;

    typedef struct packed {
        logic [FETCH_BITS-1:0] fetch_address;
        logic [1:0]            error_code;
        logic                  clear_screen;
    } out_t;

    // architectural state seen by the execute logic
    typedef struct packed {
        addr_t pc;
        lvl_t  level;
        err_t  err;
        logic [7:0] vf;
        logic [7:0] v0;
    } arch_t;

    // updates produced by one executed instruction
    typedef struct packed {
        addr_t       pc_next;
        err_t        err_next;
        logic        cls;
        logic        vf_we;
        logic [7:0]  vf_data;
        logic        ram_we;
        vidx_t       ram_waddr;
        logic [7:0]  ram_wdata;
        logic        idx_we;
        logic [11:0] idx_data;
        logic        push;
        addr_t       push_data;
        lvl_t        level_next;
    } exec_t;

endpackage
`default_nettype wire

>>> hdl/c8ie_ram.sv
`default_nettype none
// ============================================================================
// c8ie_ram : generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered (read-first).
// ============================================================================
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> hdl/c8ie_exec.sv
`default_nettype none
// ============================================================================
// c8ie_exec : instruction decode and execute
// Decodes one instruction against current state and returns all updates.
// ============================================================================
module c8ie_exec (
    input  wire c8ie_pkg::in_t   ins,
    input  wire c8ie_pkg::arch_t st,
    input  wire logic [7:0]      vx,
    input  wire logic [7:0]      vy,
    input  wire c8ie_pkg::addr_t stack_top,
    output c8ie_pkg::exec_t      ex
);

    logic [3:0]      top;
    c8ie_pkg::vidx_t x;
    c8ie_pkg::vidx_t y;
    logic [3:0]      n;
    logic [11:0]     nnn;
    logic [7:0]      kk;
    c8ie_pkg::addr_t next_pc;
    c8ie_pkg::addr_t skip_pc;
    c8ie_pkg::addr_t nnn_addr;
    logic [8:0]      sum9;
    logic            flag;
    logic            flag_we;
    logic [7:0]      res;
    logic            res_we;
    logic [7:0]      vxa;
    logic [7:0]      vya;

    assign top      = ins.instruction[15:12];
    assign x        = ins.instruction[11:8];
    assign y        = ins.instruction[7:4];
    assign n        = ins.instruction[3:0];
    assign nnn      = ins.instruction[11:0];
    assign kk       = ins.instruction[7:0];
    assign next_pc  = st.pc + c8ie_pkg::addr_t'(2);
    assign skip_pc  = st.pc + c8ie_pkg::addr_t'(4);
    assign nnn_addr = c8ie_pkg::addr_t'(nnn);
    assign sum9     = {1'b0, vx} + {1'b0, vy};

    always_comb
    begin
        ex            = '0;
        ex.pc_next    = next_pc;
        ex.err_next   = st.err;
        ex.level_next = st.level;
        ex.push_data  = next_pc;
        ex.ram_waddr  = x;
        ex.idx_data   = nnn;
        flag          = 1'b0;
        flag_we       = 1'b0;
        res           = 8'h00;
        res_we        = 1'b0;
        vxa           = vx;
        vya           = vy;

        if (st.err == c8ie_pkg::ERR_NONE)
        begin
            case (top)
                c8ie_pkg::OP_SYS:
                begin
                    if (nnn == c8ie_pkg::NNN_CLS)
                    begin
                        ex.cls = 1'b1;
                    end
                    else if (nnn == c8ie_pkg::NNN_RET)
                    begin
                        if (st.level == c8ie_pkg::lvl_t'(0))
                        begin
                            ex.err_next = c8ie_pkg::ERR_UNDERFLOW;
                        end
                        else
                        begin
                            ex.level_next = st.level - c8ie_pkg::lvl_t'(1);
                            ex.pc_next    = stack_top;
                        end
                    end
                    else
                    begin
                        ex.err_next = c8ie_pkg::ERR_UNKNOWN;
                    end
                end
                c8ie_pkg::OP_JP:   ex.pc_next = nnn_addr;
                c8ie_pkg::OP_CALL:
                begin
                    if (st.level == c8ie_pkg::lvl_t'(c8ie_pkg::STK_DEPTH))
                    begin
                        ex.err_next = c8ie_pkg::ERR_OVERFLOW;
                    end
                    else
                    begin
                        ex.push       = 1'b1;
                        ex.level_next = st.level + c8ie_pkg::lvl_t'(1);
                        ex.pc_next    = nnn_addr;
                    end
                end
                c8ie_pkg::OP_SE:   if (vx == kk) ex.pc_next = skip_pc;
                c8ie_pkg::OP_SNE:  if (vx != kk) ex.pc_next = skip_pc;
                c8ie_pkg::OP_SEV:  if (vx == vy) ex.pc_next = skip_pc;
                c8ie_pkg::OP_SNEV: if (vx != vy) ex.pc_next = skip_pc;
                c8ie_pkg::OP_LD:
                begin
                    res    = kk;
                    res_we = 1'b1;
                end
                c8ie_pkg::OP_ADD:
                begin
                    res    = vx + kk;
                    res_we = 1'b1;
                end
                c8ie_pkg::OP_ALU:
                begin
                    case (n)
                        c8ie_pkg::ALU_MOV: begin res = vy;      res_we = 1'b1; end
                        c8ie_pkg::ALU_OR:  begin res = vx | vy; res_we = 1'b1; end
                        c8ie_pkg::ALU_AND: begin res = vx & vy; res_we = 1'b1; end
                        c8ie_pkg::ALU_XOR: begin res = vx ^ vy; res_we = 1'b1; end
                        c8ie_pkg::ALU_ADD:
                        begin
                            // sum taken before the flag lands
                            flag    = sum9[8];
                            flag_we = 1'b1;
                            res     = sum9[7:0];
                            res_we  = 1'b1;
                        end
                        c8ie_pkg::ALU_SUB:
                        begin
                            flag    = (vx > vy);
                            flag_we = 1'b1;
                            vxa     = (x == c8ie_pkg::REG_VF) ? {7'd0, flag} : vx;
                            vya     = (y == c8ie_pkg::REG_VF) ? {7'd0, flag} : vy;
                            res     = vxa - vya;
                            res_we  = 1'b1;
                        end
                        c8ie_pkg::ALU_SHR:
                        begin
                            flag    = vx[0];
                            flag_we = 1'b1;
                            vxa     = (x == c8ie_pkg::REG_VF) ? {7'd0, flag} : vx;
                            res     = {1'b0, vxa[7:1]};
                            res_we  = 1'b1;
                        end
                        c8ie_pkg::ALU_SBN:
                        begin
                            flag    = (vy > vx);
                            flag_we = 1'b1;
                            vxa     = (x == c8ie_pkg::REG_VF) ? {7'd0, flag} : vx;
                            vya     = (y == c8ie_pkg::REG_VF) ? {7'd0, flag} : vy;
                            res     = vya - vxa;
                            res_we  = 1'b1;
                        end
                        c8ie_pkg::ALU_SHL:
                        begin
                            flag    = vx[7];
                            flag_we = 1'b1;
                            vxa     = (x == c8ie_pkg::REG_VF) ? {7'd0, flag} : vx;
                            res     = {vxa[6:0], 1'b0};
                            res_we  = 1'b1;
                        end
                        default:   ex.err_next = c8ie_pkg::ERR_UNKNOWN;
                    endcase
                end
                c8ie_pkg::OP_LDI:  ex.idx_we = 1'b1;
                c8ie_pkg::OP_JPV:  ex.pc_next = c8ie_pkg::addr_t'(st.v0) + nnn_addr;
                c8ie_pkg::OP_RND:
                begin
                    res    = ins.random_byte & kk;
                    res_we = 1'b1;
                end
                c8ie_pkg::OP_KEY:
                begin
                    if (kk != c8ie_pkg::KK_SKP && kk != c8ie_pkg::KK_SKNP)
                    begin
                        ex.err_next = c8ie_pkg::ERR_UNKNOWN;
                    end
                end
                default: ; // display, timer and key ops: advance only
            endcase

            // result to VF overrides the flag
            ex.vf_we     = flag_we || (res_we && x == c8ie_pkg::REG_VF);
            ex.vf_data   = (res_we && x == c8ie_pkg::REG_VF) ? res : {7'd0, flag};
            ex.ram_we    = res_we && (x != c8ie_pkg::REG_VF);
            ex.ram_wdata = res;

            if (ex.err_next != c8ie_pkg::ERR_NONE)
            begin
                ex.pc_next    = st.pc;
                ex.cls        = 1'b0;
                ex.vf_we      = 1'b0;
                ex.ram_we     = 1'b0;
                ex.idx_we     = 1'b0;
                ex.push       = 1'b0;
                ex.level_next = st.level;
            end
        end
        else
        begin
            ex.pc_next = st.pc;
        end
    end

endmodule
`default_nettype wire

>>> hdl/chip8_instruction_execute.sv
`default_nettype none
// Result: an accepted transaction has its result registered on out_data when it leaves execute.
// Throughput: one instruction per cycle while the result channel is not stalled; V0..VE and
//   the return stack live in registered-read RAMs addressed at accept, so execute uses the read data.
// Reset: V registers read as zero, index and stack level zero, no error, counter
//   at program_start (512); the return stack holds nothing valid until pushed.
// ============================================================================
// chip8_instruction_execute : CHIP-8 instruction execute core
// Two-stage core: register-file/stack read at accept, execute and write-back
// in the second stage, result held in an output register.
// ============================================================================
module chip8_instruction_execute (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // instruction channel
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire c8ie_pkg::in_t                        in_data,
    // result channel
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output c8ie_pkg::out_t                            out_data,
    // APB configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [c8ie_pkg::PADDR_BITS-1:0]      paddr,
    input  wire logic [c8ie_pkg::PDATA_BITS-1:0]      pwdata,
    output logic      [c8ie_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                      pready
);

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    logic in_accept;
    logic s1_adv;       // execute stage retires its transaction this cycle
    logic cfg_we;

    logic                  s1_valid_reg;
    c8ie_pkg::in_t         s1_data_reg;
    logic                  out_valid_reg;
    c8ie_pkg::out_t        out_data_reg;

    // architectural state kept in flops
    c8ie_pkg::addr_t       pc_reg;
    c8ie_pkg::lvl_t        level_reg;
    c8ie_pkg::err_t        err_reg;
    logic [7:0]            vf_reg;       // VF lives here, never in the RAM
    logic [7:0]            v0_reg;       // shadow of V0 for Bnnn
    logic [11:0]           index_reg;
    logic [c8ie_pkg::NUM_VREGS-1:0] vld_reg;  // RAM entry written since reset
    logic [c8ie_pkg::FETCH_BITS-1:0] prog_start_reg;

    // forwarding of the write that lands on the same edge as the RAM read
    logic                  dfwd_valid_reg;
    c8ie_pkg::vidx_t       dfwd_addr_reg;
    logic [7:0]            dfwd_data_reg;
    logic                  sfwd_valid_reg;
    c8ie_pkg::addr_t       sfwd_data_reg;

    c8ie_pkg::exec_t       ex;
    c8ie_pkg::arch_t       st;
    c8ie_pkg::lvl_t        level_eff;
    c8ie_pkg::stk_idx_t    stk_raddr;
    c8ie_pkg::vidx_t       s1_x;
    c8ie_pkg::vidx_t       s1_y;
    logic [7:0]            rd_x;
    logic [7:0]            rd_y;
    logic [7:0]            vx_mem;
    logic [7:0]            vy_mem;
    logic [7:0]            vx;
    logic [7:0]            vy;
    c8ie_pkg::addr_t       stk_rd;
    c8ie_pkg::addr_t       stack_top;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign in_accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Configuration: program_start, which also reloads the counter
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == c8ie_pkg::REG_PROGRAM_START)
        begin
            prdata = c8ie_pkg::PDATA_BITS'(prog_start_reg);
        end
    end

    // ------------------------------------------------------------------
    // Register file (V0..VE): two copies for the x and y read ports
    // ------------------------------------------------------------------
    c8ie_ram #(.WIDTH(8), .DEPTH(c8ie_pkg::NUM_VREGS)) u_vram_x (
        .clk   (clk),
        .we    (s1_adv && ex.ram_we),
        .waddr (ex.ram_waddr),
        .wdata (ex.ram_wdata),
        .re    (in_accept),
        .raddr (in_data.instruction[11:8]),
        .rdata (rd_x)
    );

    c8ie_ram #(.WIDTH(8), .DEPTH(c8ie_pkg::NUM_VREGS)) u_vram_y (
        .clk   (clk),
        .we    (s1_adv && ex.ram_we),
        .waddr (ex.ram_waddr),
        .wdata (ex.ram_wdata),
        .re    (in_accept),
        .raddr (in_data.instruction[7:4]),
        .rdata (rd_y)
    );

    // ------------------------------------------------------------------
    // Return stack: read the would-be top at accept, using the level as it
    // stands after the instruction retiring on the same edge.
    // ------------------------------------------------------------------
    assign level_eff = s1_adv ? ex.level_next : level_reg;
    assign stk_raddr = c8ie_pkg::stk_idx_t'(level_eff - c8ie_pkg::lvl_t'(1));

    c8ie_ram #(.WIDTH(c8ie_pkg::ADDR_BITS), .DEPTH(c8ie_pkg::STK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (s1_adv && ex.push),
        .waddr (c8ie_pkg::stk_idx_t'(level_reg)),
        .wdata (ex.push_data),
        .re    (in_accept),
        .raddr (stk_raddr),
        .rdata (stk_rd)
    );

    // A push on the read edge targets exactly the slot being read.
    assign stack_top = sfwd_valid_reg ? sfwd_data_reg : stk_rd;

    // ------------------------------------------------------------------
    // Operand resolution: forward, then valid bit (unwritten reads zero),
    // VF always from its flop.
    // ------------------------------------------------------------------
    assign s1_x = s1_data_reg.instruction[11:8];
    assign s1_y = s1_data_reg.instruction[7:4];

    assign vx_mem = (dfwd_valid_reg && dfwd_addr_reg == s1_x) ? dfwd_data_reg :
                    (vld_reg[s1_x] ? rd_x : 8'h00);
    assign vy_mem = (dfwd_valid_reg && dfwd_addr_reg == s1_y) ? dfwd_data_reg :
                    (vld_reg[s1_y] ? rd_y : 8'h00);
    assign vx     = (s1_x == c8ie_pkg::REG_VF) ? vf_reg : vx_mem;
    assign vy     = (s1_y == c8ie_pkg::REG_VF) ? vf_reg : vy_mem;

    assign st.pc    = pc_reg;
    assign st.level = level_reg;
    assign st.err   = err_reg;
    assign st.vf    = vf_reg;
    assign st.v0    = v0_reg;

    c8ie_exec u_exec (
        .ins       (s1_data_reg),
        .st        (st),
        .vx        (vx),
        .vy        (vy),
        .stack_top (stack_top),
        .ex        (ex)
    );

    // ------------------------------------------------------------------
    // Payload registers (no reset)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg    <= in_data;
            dfwd_addr_reg  <= ex.ram_waddr;
            dfwd_data_reg  <= ex.ram_wdata;
            sfwd_data_reg  <= ex.push_data;
        end
        if (s1_adv)
        begin
            out_data_reg.fetch_address <= ex.pc_next[c8ie_pkg::FETCH_BITS-1:0];
            out_data_reg.error_code    <= ex.err_next;
            out_data_reg.clear_screen  <= ex.cls;
        end
    end

    // ------------------------------------------------------------------
    // Control and architectural state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            dfwd_valid_reg <= 1'b0;
            sfwd_valid_reg <= 1'b0;
            prog_start_reg <= c8ie_pkg::PROG_START_RESET;
            pc_reg         <= c8ie_pkg::addr_t'(c8ie_pkg::PROG_START_RESET);
            level_reg      <= '0;
            err_reg        <= c8ie_pkg::ERR_NONE;
            vf_reg         <= 8'h00;
            v0_reg         <= 8'h00;
            index_reg      <= 12'h000;
            vld_reg        <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg   <= 1'b1;
                dfwd_valid_reg <= s1_adv && ex.ram_we;
                sfwd_valid_reg <= s1_adv && ex.push;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                pc_reg    <= ex.pc_next;
                level_reg <= ex.level_next;
                err_reg   <= ex.err_next;
                if (ex.vf_we)
                begin
                    vf_reg <= ex.vf_data;
                end
                if (ex.ram_we)
                begin
                    vld_reg[ex.ram_waddr] <= 1'b1;
                    if (ex.ram_waddr == c8ie_pkg::REG_V0)
                    begin
                        v0_reg <= ex.ram_wdata;
                    end
                end
                if (ex.idx_we)
                begin
                    index_reg <= ex.idx_data;
                end
            end

            // to be written only while idle, which the block does not enforce; also moves the counter there
            if (cfg_we && paddr[2] == c8ie_pkg::REG_PROGRAM_START)
            begin
                prog_start_reg <= pwdata[c8ie_pkg::FETCH_BITS-1:0];
                pc_reg         <= c8ie_pkg::addr_t'(pwdata[c8ie_pkg::FETCH_BITS-1:0]);
            end
        end
    end

endmodule
`default_nettype wire

>>> test/chip8_instruction_execute_test.sv
`timescale 1ns / 1ps
// ============================================================================
// chip8_instruction_execute_test : self-checking bench for the execute core
// Streams instruction transactions through the valid/ready channels with
// random idling on both sides. A shadow copy of the CHIP-8 state predicts
// every result transaction. program_start is rewritten between phases over
// the APB port and read back. The run ends by driving the core into one
// randomly chosen fault and checking that it stays halted.
// ============================================================================
module chip8_instruction_execute_test;

    localparam int LONG_HOLD      = 60;     // receiver hold-off that backs up the core
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transaction anywhere
    localparam int SETTLE_CYCLES  = 4;      // quiet cycles after the last result
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 225;
    localparam int HALTED_ITEMS   = 20;
    localparam int PRINT_CAP      = 100;

    // top nibbles the package leaves unnamed: display and timer/key groups,
    // both of which only advance the counter
    localparam logic [3:0] OP_DRAW = 4'hD;
    localparam logic [3:0] OP_MISC = 4'hF;

    localparam logic [c8ie_pkg::PADDR_BITS-1:0] START_ADDR =
        {c8ie_pkg::REG_PROGRAM_START, 2'b00};

    // ------------------------------------------------------------------------
    // Shadow of the core's architectural state. execute() runs one accepted
    // instruction and queues the result it must produce; compare() checks a
    // result transaction against the oldest queued one.
    // ------------------------------------------------------------------------
    class chip8_shadow;
        logic [7:0]      vreg [c8ie_pkg::NUM_VREGS];
        c8ie_pkg::addr_t index_reg;
        c8ie_pkg::addr_t pc;
        c8ie_pkg::addr_t start_addr;
        c8ie_pkg::addr_t ret_stack [c8ie_pkg::STK_DEPTH];
        int              depth;
        c8ie_pkg::err_t  fault;
        c8ie_pkg::out_t  expected_results [$];
        int              mismatches;

        function new();
            foreach (vreg[i]) vreg[i] = 8'h00;
            foreach (ret_stack[i]) ret_stack[i] = '0;
            index_reg  = '0;
            start_addr = c8ie_pkg::PROG_START_RESET;
            pc         = c8ie_pkg::PROG_START_RESET;
            depth      = 0;
            fault      = c8ie_pkg::ERR_NONE;
            mismatches = 0;
        endfunction

        // a program_start write also moves the counter, even when halted
        function void load_start(c8ie_pkg::addr_t value);
            start_addr = value;
            pc         = value;
        endfunction

        function void execute(c8ie_pkg::in_t item);
            logic [3:0]      op;
            logic [3:0]      x;
            logic [3:0]      y;
            logic [3:0]      sub;
            logic [11:0]     nnn;
            logic [7:0]      kk;
            logic [8:0]      sum;
            c8ie_pkg::addr_t here;
            c8ie_pkg::addr_t new_pc;
            logic            cls;
            c8ie_pkg::out_t  res;
            op     = item.instruction[15:12];
            x      = item.instruction[11:8];
            y      = item.instruction[7:4];
            sub    = item.instruction[3:0];
            nnn    = item.instruction[11:0];
            kk     = item.instruction[7:0];
            here   = pc;
            new_pc = here + c8ie_pkg::addr_t'(2);
            cls    = 1'b0;
            if (fault == c8ie_pkg::ERR_NONE)
            begin
                case (op)
                    c8ie_pkg::OP_SYS:
                    begin
                        if (nnn == c8ie_pkg::NNN_CLS)
                        begin
                            cls = 1'b1;
                        end
                        else if (nnn == c8ie_pkg::NNN_RET)
                        begin
                            if (depth == 0)
                            begin
                                fault = c8ie_pkg::ERR_UNDERFLOW;
                            end
                            else
                            begin
                                depth--;
                                new_pc = ret_stack[depth];
                            end
                        end
                        else
                        begin
                            fault = c8ie_pkg::ERR_UNKNOWN;
                        end
                    end
                    c8ie_pkg::OP_JP: new_pc = nnn;
                    c8ie_pkg::OP_CALL:
                    begin
                        if (depth >= c8ie_pkg::STK_DEPTH)
                        begin
                            fault = c8ie_pkg::ERR_OVERFLOW;
                        end
                        else
                        begin
                            ret_stack[depth] = new_pc;
                            depth++;
                            new_pc = nnn;
                        end
                    end
                    c8ie_pkg::OP_SE:
                        if (vreg[x] == kk) new_pc = here + c8ie_pkg::addr_t'(4);
                    c8ie_pkg::OP_SNE:
                        if (vreg[x] != kk) new_pc = here + c8ie_pkg::addr_t'(4);
                    c8ie_pkg::OP_SEV:
                        if (vreg[x] == vreg[y]) new_pc = here + c8ie_pkg::addr_t'(4);
                    c8ie_pkg::OP_SNEV:
                        if (vreg[x] != vreg[y]) new_pc = here + c8ie_pkg::addr_t'(4);
                    c8ie_pkg::OP_LD:   vreg[x] = kk;
                    c8ie_pkg::OP_ADD:  vreg[x] = vreg[x] + kk;
                    c8ie_pkg::OP_ALU:
                    begin
                        // VF goes first except for add; the result then
                        // reads the registers as they stand, so x = F wins
                        case (sub)
                            c8ie_pkg::ALU_MOV: vreg[x] = vreg[y];
                            c8ie_pkg::ALU_OR:  vreg[x] = vreg[x] | vreg[y];
                            c8ie_pkg::ALU_AND: vreg[x] = vreg[x] & vreg[y];
                            c8ie_pkg::ALU_XOR: vreg[x] = vreg[x] ^ vreg[y];
                            c8ie_pkg::ALU_ADD:
                            begin
                                sum = {1'b0, vreg[x]} + {1'b0, vreg[y]};
                                vreg[c8ie_pkg::REG_VF] = {7'd0, sum[8]};
                                vreg[x] = sum[7:0];
                            end
                            c8ie_pkg::ALU_SUB:
                            begin
                                vreg[c8ie_pkg::REG_VF] = (vreg[x] > vreg[y]) ? 8'd1 : 8'd0;
                                vreg[x] = vreg[x] - vreg[y];
                            end
                            c8ie_pkg::ALU_SHR:
                            begin
                                vreg[c8ie_pkg::REG_VF] = {7'd0, vreg[x][0]};
                                vreg[x] = vreg[x] >> 1;
                            end
                            c8ie_pkg::ALU_SBN:
                            begin
                                vreg[c8ie_pkg::REG_VF] = (vreg[y] > vreg[x]) ? 8'd1 : 8'd0;
                                vreg[x] = vreg[y] - vreg[x];
                            end
                            c8ie_pkg::ALU_SHL:
                            begin
                                vreg[c8ie_pkg::REG_VF] = {7'd0, vreg[x][7]};
                                vreg[x] = vreg[x] << 1;
                            end
                            default: fault = c8ie_pkg::ERR_UNKNOWN;
                        endcase
                    end
                    c8ie_pkg::OP_LDI: index_reg = nnn;
                    c8ie_pkg::OP_JPV:
                        new_pc = c8ie_pkg::addr_t'(vreg[c8ie_pkg::REG_V0]) + nnn;
                    c8ie_pkg::OP_RND: vreg[x] = item.random_byte & kk;
                    c8ie_pkg::OP_KEY:
                        if (kk != c8ie_pkg::KK_SKP && kk != c8ie_pkg::KK_SKNP)
                            fault = c8ie_pkg::ERR_UNKNOWN;
                    default: ;
                endcase
                // a faulting instruction leaves the counter on itself
                if (fault != c8ie_pkg::ERR_NONE)
                begin
                    new_pc = here;
                    cls    = 1'b0;
                end
                pc = new_pc;
            end
            res.fetch_address = pc;
            res.error_code    = fault;
            res.clear_screen  = cls;
            expected_results.push_back(res);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task compare(c8ie_pkg::out_t got);
            c8ie_pkg::out_t want;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %p", got));
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.fetch_address !== want.fetch_address)
                    report_mismatch($sformatf("fetch_address %03h, expected %03h",
                                              got.fetch_address, want.fetch_address));
                if (got.error_code !== want.error_code)
                    report_mismatch($sformatf("error_code %0d, expected %0d",
                                              got.error_code, want.error_code));
                if (got.clear_screen !== want.clear_screen)
                    report_mismatch($sformatf("clear_screen %b, expected %b",
                                              got.clear_screen, want.clear_screen));
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals; every input of the core holds a known value from time zero
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    c8ie_pkg::in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    c8ie_pkg::out_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [c8ie_pkg::PADDR_BITS-1:0] paddr = '0;
    logic [c8ie_pkg::PDATA_BITS-1:0] pwdata = '0;
    logic [c8ie_pkg::PDATA_BITS-1:0] prdata;
    logic pready;

    chip8_shadow shadow;

    // idling controls, set by the main sequence
    bit sender_idling = 1'b1;
    bit ready_idling  = 1'b1;
    bit hold_request  = 1'b0;

    // legal ALU sub-ops, for random picks
    logic [3:0] alu_ops [9] = '{c8ie_pkg::ALU_MOV, c8ie_pkg::ALU_OR, c8ie_pkg::ALU_AND,
                                c8ie_pkg::ALU_XOR, c8ie_pkg::ALU_ADD, c8ie_pkg::ALU_SUB,
                                c8ie_pkg::ALU_SHR, c8ie_pkg::ALU_SBN, c8ie_pkg::ALU_SHL};

    // opening directed transactions: flag corner cases, most groups of
    // opcodes, counter wrap via Bnnn and a skip sitting at the top of memory
    logic [15:0] opening_ops [25] = '{
        {c8ie_pkg::OP_SYS, c8ie_pkg::NNN_CLS},
        {c8ie_pkg::OP_LD, 4'h0, 8'hFF},
        {c8ie_pkg::OP_LD, 4'h1, 8'h01},
        {c8ie_pkg::OP_ALU, 4'h0, 4'h1, c8ie_pkg::ALU_ADD},      // carry out
        {c8ie_pkg::OP_ALU, 4'h0, 4'h1, c8ie_pkg::ALU_SUB},      // borrow
        {c8ie_pkg::OP_ALU, 4'h0, 4'h1, c8ie_pkg::ALU_SBN},
        {c8ie_pkg::OP_LD, 4'h2, 8'h80},
        {c8ie_pkg::OP_ALU, 4'h2, 4'h0, c8ie_pkg::ALU_SHL},      // flag from bit 7
        {c8ie_pkg::OP_LD, 4'h3, 8'h81},
        {c8ie_pkg::OP_ALU, 4'h3, 4'h0, c8ie_pkg::ALU_SHR},      // flag from bit 0
        {c8ie_pkg::OP_LD, c8ie_pkg::REG_VF, 8'h03},
        {c8ie_pkg::OP_ALU, c8ie_pkg::REG_VF, 4'h0, c8ie_pkg::ALU_SHR},  // result over flag
        {c8ie_pkg::OP_ALU, 4'h0, 4'h1, c8ie_pkg::ALU_MOV},
        {c8ie_pkg::OP_ALU, 4'h1, 4'h2, c8ie_pkg::ALU_OR},
        {c8ie_pkg::OP_LDI, 12'hFFF},
        {c8ie_pkg::OP_RND, 4'h0, 8'hFF},
        {c8ie_pkg::OP_JPV, 12'hFFF},                  // V0 + nnn wraps
        {c8ie_pkg::OP_JP, 12'hFFE},
        {c8ie_pkg::OP_SE, 4'h5, 8'h00},               // taken skip wraps past 0xFFF
        {c8ie_pkg::OP_SEV, 4'h0, 4'h1, 4'hF},
        {c8ie_pkg::OP_KEY, 4'h0, c8ie_pkg::KK_SKP},
        {c8ie_pkg::OP_KEY, 4'hF, c8ie_pkg::KK_SKNP},
        {OP_MISC, 12'hFFF},
        {c8ie_pkg::OP_CALL, 12'hABC},
        {c8ie_pkg::OP_SYS, c8ie_pkg::NNN_RET}
    };

    always #5 clk = ~clk;

    chip8_instruction_execute i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // ------------------------------------------------------------------------
    // Result side: out_ready changes on the falling edge. Random stall bursts,
    // plus one long hold-off on request that backs the core up into its input
    // channel.
    // ------------------------------------------------------------------------
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            stall_left   = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (ready_idling && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // result transactions are checked on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) shadow.compare(out_data);
    end

    // watchdog: any transaction on either channel or the APB port clears it
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[chip8_instruction_execute] ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers; all tasks start and end on a falling edge
    // ------------------------------------------------------------------------

    // Offers one instruction transaction. Valid stays high into the next call
    // unless that call opens a gap, so back-to-back transactions never drop it.
    task automatic send_item(input c8ie_pkg::in_t item);
        if (sender_idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        shadow.execute(item);
        @(negedge clk);
    endtask

    // sender goes quiet until every predicted result has been seen
    task automatic drain_results();
        in_valid <= 1'b0;
        while (shadow.expected_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_start(input c8ie_pkg::addr_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= START_ADDR;
        pwdata  <= {$urandom} & ~32'hFFF | {20'd0, value};   // junk above bit 11
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        shadow.load_start(value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // bus returns to idle before the next access
        @(negedge clk);
    endtask

    task automatic read_start();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= START_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[11:0] !== shadow.start_addr)
            shadow.report_mismatch($sformatf("program_start reads %03h, expected %03h",
                                             prdata[11:0], shadow.start_addr));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Random well-formed instruction. Stack ops are steered by the current
    // depth so the core never faults before the closing phase; skip operands
    // often match the register so both skip outcomes show up.
    function automatic c8ie_pkg::in_t next_instruction();
        c8ie_pkg::in_t item;
        logic [3:0]    x;
        logic [3:0]    y;
        int            pick;
        bit            want_ret;
        x = 4'($urandom_range(0, 15));
        y = 4'($urandom_range(0, 15));
        item.random_byte = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            item.instruction = {c8ie_pkg::OP_SYS, c8ie_pkg::NNN_CLS};
        end
        else if (pick < 22)
        begin
            want_ret = (pick < 14);
            if (shadow.depth == 0) want_ret = 1'b0;
            if (shadow.depth >= c8ie_pkg::STK_DEPTH) want_ret = 1'b1;
            item.instruction = want_ret ? {c8ie_pkg::OP_SYS, c8ie_pkg::NNN_RET}
                                        : {c8ie_pkg::OP_CALL, 12'($urandom)};
        end
        else if (pick < 28)
        begin
            item.instruction = {c8ie_pkg::OP_JP, 12'($urandom)};
        end
        else if (pick < 34)
        begin
            item.instruction = {c8ie_pkg::OP_JPV, 12'($urandom)};
        end
        else if (pick < 44)
        begin
            item.instruction = {($urandom_range(0, 1) ? c8ie_pkg::OP_SE : c8ie_pkg::OP_SNE),
                                x,
                                ($urandom_range(0, 1) ? shadow.vreg[x] : 8'($urandom))};
        end
        else if (pick < 52)
        begin
            if ($urandom_range(0, 2) == 0) y = x;
            item.instruction = {($urandom_range(0, 1) ? c8ie_pkg::OP_SEV : c8ie_pkg::OP_SNEV),
                                x, y, 4'($urandom)};
        end
        else if (pick < 62)
        begin
            item.instruction = {c8ie_pkg::OP_LD, x, 8'($urandom)};
        end
        else if (pick < 70)
        begin
            item.instruction = {c8ie_pkg::OP_ADD, x, 8'($urandom)};
        end
        else if (pick < 88)
        begin
            item.instruction = {c8ie_pkg::OP_ALU, x, y, alu_ops[$urandom_range(0, 8)]};
        end
        else if (pick < 91)
        begin
            item.instruction = {c8ie_pkg::OP_LDI, 12'($urandom)};
        end
        else if (pick < 95)
        begin
            item.instruction = {c8ie_pkg::OP_RND, x, 8'($urandom)};
        end
        else if (pick < 98)
        begin
            item.instruction = {c8ie_pkg::OP_KEY, x,
                                ($urandom_range(0, 1) ? c8ie_pkg::KK_SKP : c8ie_pkg::KK_SKNP)};
        end
        else
        begin
            item.instruction = {($urandom_range(0, 1) ? OP_DRAW : OP_MISC), 12'($urandom)};
        end
        return item;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        c8ie_pkg::in_t   item;
        c8ie_pkg::addr_t start;
        c8ie_pkg::err_t  fault_kind;
        shadow = new();

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset value of program_start, then the directed opening run from it
        read_start();
        foreach (opening_ops[i])
        begin
            item.instruction = opening_ops[i];
            item.random_byte = (i % 2) ? 8'hFF : 8'h00;
            send_item(item);
        end
        drain_results();

        // Random phases, each from a fresh program_start. Idling patterns rotate
        // so some phases run with one or both sides never idle; the last phase
        // has no idling at all.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       start = 12'h000;
                1:       start = 12'hFFF;
                2:       start = 12'hFFE;
                default: start = c8ie_pkg::addr_t'($urandom);
            endcase
            write_start(start);
            read_start();
            sender_idling = (p != NUM_PHASES - 1) && (p % 3 != 1);
            ready_idling  = (p != NUM_PHASES - 1) && (p % 3 != 2);

            // full-depth call chain unwound again: stack full without overflow
            if (p == 0)
            begin
                repeat (c8ie_pkg::STK_DEPTH)
                begin
                    item.instruction = {c8ie_pkg::OP_CALL, 12'($urandom)};
                    item.random_byte = 8'($urandom);
                    send_item(item);
                end
                repeat (c8ie_pkg::STK_DEPTH)
                begin
                    item.instruction = {c8ie_pkg::OP_SYS, c8ie_pkg::NNN_RET};
                    item.random_byte = 8'($urandom);
                    send_item(item);
                end
            end

            // long receiver hold-off while transactions keep being offered
            if (p == 1) hold_request = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // mid-phase pause in the sender until the core runs dry
                if (p == 3 && n == PHASE_ITEMS / 2) drain_results();
                send_item(next_instruction());
            end
            drain_results();
        end

        // Closing phase: reach one fault, chosen at random, then confirm the
        // core holds it, including across a program_start write.
        fault_kind = c8ie_pkg::err_t'($urandom_range(1, 3));
        item.random_byte = 8'($urandom);
        case (fault_kind)
            c8ie_pkg::ERR_OVERFLOW:
            begin
                while (shadow.depth < c8ie_pkg::STK_DEPTH)
                begin
                    item.instruction = {c8ie_pkg::OP_CALL, 12'($urandom)};
                    send_item(item);
                end
                item.instruction = {c8ie_pkg::OP_CALL, 12'($urandom)};
            end
            c8ie_pkg::ERR_UNDERFLOW:
            begin
                while (shadow.depth > 0)
                begin
                    item.instruction = {c8ie_pkg::OP_SYS, c8ie_pkg::NNN_RET};
                    send_item(item);
                end
                item.instruction = {c8ie_pkg::OP_SYS, c8ie_pkg::NNN_RET};
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        do item.instruction = {c8ie_pkg::OP_SYS, 12'($urandom)};
                        while (item.instruction[11:0] == c8ie_pkg::NNN_CLS ||
                               item.instruction[11:0] == c8ie_pkg::NNN_RET);
                    end
                    1:
                    begin
                        do item.instruction = {c8ie_pkg::OP_ALU, 8'($urandom),
                                               4'($urandom_range(8, 15))};
                        while (item.instruction[3:0] == c8ie_pkg::ALU_SHL);
                    end
                    default:
                    begin
                        do item.instruction = {c8ie_pkg::OP_KEY, 12'($urandom)};
                        while (item.instruction[7:0] == c8ie_pkg::KK_SKP ||
                               item.instruction[7:0] == c8ie_pkg::KK_SKNP);
                    end
                endcase
            end
        endcase
        send_item(item);
        repeat (HALTED_ITEMS / 2)
        begin
            item.instruction = 16'($urandom);
            item.random_byte = 8'($urandom);
            send_item(item);
        end
        drain_results();
        write_start(c8ie_pkg::addr_t'($urandom));
        read_start();
        repeat (HALTED_ITEMS / 2)
        begin
            item.instruction = 16'($urandom);
            item.random_byte = 8'($urandom);
            send_item(item);
        end
        drain_results();

        if (shadow.mismatches == 0)
            $display("[chip8_instruction_execute] OK");
        else
            $display("[chip8_instruction_execute] ERROR");
        $finish;
    end

endmodule
